[sv/hct_pkg.sv]
`default_nettype none
package hct_pkg;

   // message kinds on the request channel
   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_APP   = 2'd1,
      KIND_END   = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   // work for the table engine
   typedef enum logic [1:0] {
      OP_EMIT = 2'd0,
      OP_APP  = 2'd1,
      OP_END  = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_PASS   = 2'd1,
      ST_APPEND = 2'd2,
      ST_EMIT   = 2'd3
   } state_type;

   localparam int QUEUE_DEPTH = 2;
   localparam logic [14:0] DEADLINE_SCALE = 15'd120;
   localparam logic [14:0] DEADLINE_BIAS = 15'd60;
   localparam logic [15:0] PERIOD_RESET = 16'd60000;
   localparam logic [0:0] REG_SWEEP_PERIOD = 1'b0;

   typedef struct packed {
      op_type      op;
      logic [31:0] address;
      logic [15:0] port;
      logic [14:0] deadline;
      logic [31:0] now;
      logic [15:0] elapsed;
   } cmd_type;

   typedef struct packed {
      logic [31:0] address;
      logic [15:0] port;
      logic [31:0] last_seen;
      logic [14:0] deadline;
   } entry_type;

endpackage
`default_nettype wire

[sv/hct_front.sv]
`default_nettype none
module hct_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [1:0]       req_kind,
   input  wire logic             req_local_match,
   input  wire logic [31:0]      req_client_address,
   input  wire logic [15:0]      req_client_port,
   input  wire logic [7:0]       req_interval_minutes,
   input  wire logic [31:0]      req_now_seconds,
   input  wire logic [15:0]      req_elapsed_ms,
   output logic                  q_valid,
   output hct_pkg::cmd_type      q_cmd,
   input  wire logic             q_pop
);
   import hct_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wptr_ff, wptr_in;
   logic [PTR_W-1:0]    rptr_ff, rptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                push;
   cmd_type             cmd;

   // classify the beat
   always_comb begin
      cmd.address = req_client_address;
      cmd.port = req_client_port;
      cmd.now = req_now_seconds;
      cmd.elapsed = req_elapsed_ms;
      cmd.deadline = {7'd0, req_interval_minutes} * DEADLINE_SCALE + DEADLINE_BIAS;
      case (kind_type'(req_kind))
         KIND_TICK: cmd.op = OP_TICK;
         KIND_APP:  cmd.op = req_local_match ? OP_APP : OP_EMIT;
         KIND_END:  cmd.op = req_local_match ? OP_END : OP_EMIT;
         default:   cmd.op = OP_EMIT;
      endcase
   end

   assign busy = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign push = start && !busy;
   assign q_valid = (fill_ff != '0);
   assign q_cmd = queue_ff[rptr_ff];

   // queue pointers
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (q_pop && q_valid) begin
         rptr_in = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !(q_pop && q_valid)) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop && q_valid) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wptr_ff] <= cmd;
      end
   end

endmodule
`default_nettype wire

[sv/hct_back.sv]
`default_nettype none
module hct_back #(
   parameter int MAX_CLIENTS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [15:0]      sweep_period,
   input  wire logic             q_valid,
   input  wire hct_pkg::cmd_type q_cmd,
   output logic                  q_pop,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_dest_address,
   output logic [15:0]           rsp_dest_port,
   output logic                  rsp_last_of_run
);
   import hct_pkg::*;

   localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
   localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

   entry_type         table_mem [MAX_CLIENTS];
   entry_type         rdata_ff;
   state_type         state_ff, state_in;
   cmd_type           cmd_ff;
   logic [CNT_W-1:0]  cnt_ff, rd_ff, wr_ff, pidx_ff;
   logic              pend_ff, found_ff;
   logic [16:0]       acc_ff;
   logic [16:0]       acc_sum;
   logic              sweep_due;
   logic              issue, pass_done;
   logic              match, expired, drop, upd;
   logic              we;
   logic [CNT_W-1:0]  waddr;
   entry_type         wdata;
   entry_type         fresh;

   // tick accumulation
   assign acc_sum = acc_ff + {1'b0, q_cmd.elapsed};
   assign sweep_due = (acc_sum >= {1'b0, sweep_period});

   // per-entry decisions on the registered read data
   assign issue = (rd_ff < cnt_ff);
   assign pass_done = !issue && !pend_ff;
   assign match = (rdata_ff.address == cmd_ff.address) && (rdata_ff.port == cmd_ff.port);
   assign expired = ((cmd_ff.now - rdata_ff.last_seen) > {17'd0, rdata_ff.deadline});
   assign drop = ((cmd_ff.op == OP_TICK) && expired) || ((cmd_ff.op == OP_END) && match);
   assign upd = (cmd_ff.op == OP_APP) && match;

   always_comb begin
      fresh.address = cmd_ff.address;
      fresh.port = cmd_ff.port;
      fresh.last_seen = cmd_ff.now;
      fresh.deadline = cmd_ff.deadline;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op)
                  OP_TICK: state_in = sweep_due ? ST_PASS : ST_IDLE;
                  OP_EMIT: state_in = ST_EMIT;
                  default: state_in = ST_PASS;
               endcase
            end
         end
         ST_PASS: begin
            if (pass_done) begin
               if (cmd_ff.op == OP_TICK) begin
                  state_in = ST_IDLE;
               end else if ((cmd_ff.op == OP_APP) && !found_ff &&
                            (wr_ff < CNT_W'(MAX_CLIENTS))) begin
                  state_in = ST_APPEND;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_APPEND: state_in = ST_EMIT;
         ST_EMIT: begin
            if (pass_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and memory write port
   always_comb begin
      q_pop = 1'b0;
      we = 1'b0;
      waddr = wr_ff;
      wdata = rdata_ff;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: q_pop = q_valid;
         ST_PASS: begin
            we = pend_ff && !drop;
            wdata = upd ? fresh : rdata_ff;
         end
         ST_APPEND: begin
            we = 1'b1;
            waddr = cnt_ff;
            wdata = fresh;
         end
         ST_EMIT: rsp_valid = pend_ff;
         default: q_pop = 1'b0;
      endcase
   end

   assign rsp_dest_address = rdata_ff.address;
   assign rsp_dest_port = rdata_ff.port;
   assign rsp_last_of_run = (pidx_ff == CNT_W'(cnt_ff - 1'b1));

   // table memory
   always_ff @(posedge clock) begin
      if (we) begin
         table_mem[waddr[IDX_W-1:0]] <= wdata;
      end
      rdata_ff <= table_mem[rd_ff[IDX_W-1:0]];
   end

   // command register
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid) begin
         cmd_ff <= q_cmd;
      end
   end

   // control state and walk counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rd_ff <= '0;
         wr_ff <= '0;
         pidx_ff <= '0;
         pend_ff <= 1'b0;
         found_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               rd_ff <= '0;
               wr_ff <= '0;
               pend_ff <= 1'b0;
               found_ff <= 1'b0;
               if (q_valid && q_cmd.op == OP_TICK) begin
                  acc_ff <= sweep_due ? '0 : acc_sum;
               end
            end
            ST_PASS: begin
               pend_ff <= issue;
               if (issue) begin
                  rd_ff <= rd_ff + 1'b1;
               end
               if (pend_ff && !drop) begin
                  wr_ff <= wr_ff + 1'b1;
               end
               if (pend_ff && upd) begin
                  found_ff <= 1'b1;
               end
               if (pass_done) begin
                  cnt_ff <= wr_ff;
                  rd_ff <= '0;
               end
            end
            ST_APPEND: begin
               cnt_ff <= cnt_ff + 1'b1;
               rd_ff <= '0;
               pend_ff <= 1'b0;
            end
            ST_EMIT: begin
               pend_ff <= issue;
               pidx_ff <= rd_ff;
               if (issue) begin
                  rd_ff <= rd_ff + 1'b1;
               end
            end
            default: pend_ff <= 1'b0;
         endcase
      end
   end

endmodule
`default_nettype wire

[sv/heartbeat_client_table.sv]
// a message beat makes an edit pass over the table memory, then sends one result beat
// per client; a message that leaves the table alone sends only the result beats; a tick
// walks the table only with a sweep. each beat is registered in the queue first.
// one table memory port walks one entry per cycle; the engine works one beat to its end
// before it pops the next, and a two-deep queue takes beats ahead of the engine.
// results leave on a one-cycle strobe that the receiver cannot stall.
// reset empties the table and the tick accumulator and sets the sweep period to 60000.
`default_nettype none
module heartbeat_client_table #(
   parameter int MAX_CLIENTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic        req_local_match,
   input  wire logic [31:0] req_client_address,
   input  wire logic [15:0] req_client_port,
   input  wire logic [7:0]  req_interval_minutes,
   input  wire logic [31:0] req_now_seconds,
   input  wire logic [15:0] req_elapsed_ms,
   output logic             rsp_valid,
   output logic [31:0]      rsp_dest_address,
   output logic [15:0]      rsp_dest_port,
   output logic             rsp_last_of_run,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import hct_pkg::*;

   logic [15:0] period_ff;
   logic        q_valid;
   logic        q_pop;
   cmd_type     q_cmd;
   logic        reg_hit;

   // configuration register
   assign pready = 1'b1;
   assign reg_hit = (paddr[1:0] == 2'b00) && (paddr[2] == REG_SWEEP_PERIOD);
   assign prdata = reg_hit ? {16'd0, period_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         period_ff <= pwdata[15:0];
      end
   end

   // accept and classify
   hct_front u_front (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_kind             (req_kind),
      .req_local_match      (req_local_match),
      .req_client_address   (req_client_address),
      .req_client_port      (req_client_port),
      .req_interval_minutes (req_interval_minutes),
      .req_now_seconds      (req_now_seconds),
      .req_elapsed_ms       (req_elapsed_ms),
      .q_valid              (q_valid),
      .q_cmd                (q_cmd),
      .q_pop                (q_pop)
   );

   // table engine
   hct_back #(
      .MAX_CLIENTS (MAX_CLIENTS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .sweep_period     (period_ff),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_dest_address (rsp_dest_address),
      .rsp_dest_port    (rsp_dest_port),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
`default_nettype wire
